[sv/ffsd_pkg.sv]
// ffsd_pkg: shared constants, register codes and types of the serial deframer
// no dependencies; compile first
package ffsd_pkg;

	localparam int FRAME_BYTES_DEF = 16;
	localparam int CMD_POS         = 1;
	localparam int ID_POS          = 3;
	localparam int ID_LEN          = 4;
	localparam int DATA_POS        = 7;
	localparam int DATA_LEN        = 8;

	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_HEADER   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TAIL     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_FEEDBACK = 2'd2;

	localparam logic [7:0] HEADER_RST   = 8'hAA;
	localparam logic [7:0] TAIL_RST     = 8'h55;
	localparam logic [7:0] FEEDBACK_RST = 8'h11;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] tail_byte;
		logic [7:0] feedback_code;
	} cfg_t;

	typedef struct packed {
		logic                    valid;
		logic [8*ID_LEN-1:0]     can_id;
		logic [8*DATA_LEN-1:0]   payload;
	} frame_t;

endpackage

[sv/ffsd_if.sv]
// ffsd_if: valid/ready channels of the deframer (receive word, frame result, config write)
// depends on ffsd_pkg
interface ffsd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ffsd_frame_if;
	logic                              valid;
	logic                              ready;
	logic [8*ffsd_pkg::ID_LEN-1:0]     can_id;
	logic [8*ffsd_pkg::DATA_LEN-1:0]   payload;

	modport source (output valid, output can_id, output payload, input ready);
	modport sink   (input valid, input can_id, input payload, output ready);
endinterface

interface ffsd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ffsd_pkg::REG_IDX_W-1:0]    wr_index;
	logic [7:0]                        wr_data;

	modport source (output valid, output wr_index, output wr_data, input ready);
	modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

[sv/ffsd_cfg_regs.sv]
// ffsd_cfg_regs: header, tail and feedback code registers with write port
// depends on ffsd_pkg
module ffsd_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_valid,
	output logic                            wr_ready,
	input  logic [ffsd_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [7:0]                      wr_data,
	output ffsd_pkg::cfg_t                  cfg
);
	import ffsd_pkg::*;

	cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte   <= HEADER_RST;
			cfg_q.tail_byte     <= TAIL_RST;
			cfg_q.feedback_code <= FEEDBACK_RST;
		end else if (wr_valid) begin
			unique case (wr_index)
				REG_HEADER:   cfg_q.header_byte   <= wr_data;
				REG_TAIL:     cfg_q.tail_byte     <= wr_data;
				REG_FEEDBACK: cfg_q.feedback_code <= wr_data;
				default:      cfg_q               <= cfg_q;
			endcase
		end
	end

endmodule

[sv/ffsd_window.sv]
// ffsd_window: input word register, sliding byte window with fill count, frame check
// depends on ffsd_pkg
module ffsd_window #(
	parameter int FRAME_BYTES = ffsd_pkg::FRAME_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  ffsd_pkg::cfg_t   cfg,
	input  logic             out_free,
	output ffsd_pkg::frame_t frame
);
	import ffsd_pkg::*;

	localparam int FILL_W = $clog2(FRAME_BYTES + 1);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic [7:0]        win_q [FRAME_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        new_win [FRAME_BYTES];
	logic              full;
	logic              hit;
	logic              emit;
	logic              adv;

	// window after the pending word is shifted in
	always_comb begin
		for (int i = 0; i < FRAME_BYTES - 1; i++) begin
			new_win[i] = win_q[i+1];
		end
		new_win[FRAME_BYTES-1] = byte_s1;
	end

	assign full = fill_q >= FILL_W'(FRAME_BYTES - 1);
	assign hit  = valid_s1 && full && (new_win[0] == cfg.header_byte)
	              && (new_win[FRAME_BYTES-1] == cfg.tail_byte);
	assign emit = hit && (new_win[CMD_POS] == cfg.feedback_code);
	assign adv  = valid_s1 && (out_free || !emit);

	assign in_ready = !valid_s1 || adv;

	always_comb begin
		frame.valid = adv && emit;
		for (int k = 0; k < ID_LEN; k++) begin
			frame.can_id[8*k +: 8] = new_win[ID_POS + k];
		end
		for (int k = 0; k < DATA_LEN; k++) begin
			frame.payload[8*k +: 8] = new_win[DATA_POS + k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			win_q <= new_win;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (adv) begin
			priority if (hit) begin
				fill_q <= '0;
			end else if (full) begin
				fill_q <= FILL_W'(FRAME_BYTES);
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

[sv/ffsd_out_buf.sv]
// ffsd_out_buf: result register holding one frame word until taken
// depends on ffsd_pkg
module ffsd_out_buf (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ffsd_pkg::frame_t                    frame,
	output logic                                out_free,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [8*ffsd_pkg::ID_LEN-1:0]       can_id,
	output logic [8*ffsd_pkg::DATA_LEN-1:0]     payload
);
	import ffsd_pkg::*;

	logic                    valid_q;
	logic [8*ID_LEN-1:0]     can_id_q;
	logic [8*DATA_LEN-1:0]   payload_q;

	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign can_id    = can_id_q;
	assign payload   = payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && frame.valid) begin
			can_id_q  <= frame.can_id;
			payload_q <= frame.payload;
		end
	end

endmodule

[sv/fixed_frame_serial_deframer.sv]
// fixed_frame_serial_deframer: header/tail fixed-length deframer, top level
// result path: the completing word sits in the input word register; its frame is then registered in the result register
// throughput: one received word per cycle; held off only while a result waits untaken
// reset: config registers to defaults, fill count and valids cleared; window data not reset
// depends on ffsd_pkg, ffsd_if, ffsd_cfg_regs, ffsd_window, ffsd_out_buf
module fixed_frame_serial_deframer #(
	parameter int FRAME_BYTES = ffsd_pkg::FRAME_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	ffsd_rx_if.sink           rx,
	ffsd_frame_if.source      frame_out,
	ffsd_cfg_if.sink          cfg
);
	import ffsd_pkg::*;

	cfg_t   cfg_val;
	frame_t frame;
	logic   out_free;

	ffsd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.wr_index),
		.wr_data  (cfg.wr_data),
		.cfg      (cfg_val)
	);

	ffsd_window #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.in_byte  (rx.rx_byte),
		.cfg      (cfg_val),
		.out_free (out_free),
		.frame    (frame)
	);

	ffsd_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame),
		.out_free  (out_free),
		.out_valid (frame_out.valid),
		.out_ready (frame_out.ready),
		.can_id    (frame_out.can_id),
		.payload   (frame_out.payload)
	);

endmodule

[sv/ffsd_checker.sv]
// ffsd_checker: port-level checks of the deframer, bound to the top level
// depends on ffsd_pkg and fixed_frame_serial_deframer
module ffsd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                rx_valid,
	input logic                                rx_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [8*ffsd_pkg::DATA_LEN-1:0]     payload
);
	import ffsd_pkg::*;

	// result word held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(payload))
		else $error("payload changed while stalled");

	// receive side only stalls behind an untaken result
	a_rx_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> out_valid && !out_ready)
		else $error("receive stalled with output free");

	// a new result traces back to a word accepted on the receive side
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(rx_valid && rx_ready, 2))
		else $error("result without a completing word");

endmodule

bind fixed_frame_serial_deframer ffsd_checker u_ffsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_valid  (rx.valid),
	.rx_ready  (rx.ready),
	.out_valid (frame_out.valid),
	.out_ready (frame_out.ready),
	.payload   (frame_out.payload)
);

[tb/sv/ffsd_frame_checker.sv]
`timescale 1ns / 100ps
// ffsd_frame_checker: watches the receive, frame and config channels of the deframer,
// predicts the frames each received word completes and compares them with the output
// depends on ffsd_pkg and ffsd_if
module ffsd_frame_checker #(
	parameter int FRAME_BYTES = ffsd_pkg::FRAME_BYTES_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	ffsd_rx_if     rx,
	ffsd_frame_if  frame_out,
	ffsd_cfg_if    cfg,
	output int     fail_count,
	output int     pend_count
);
	import ffsd_pkg::*;

	typedef struct packed {
		logic [8*ID_LEN-1:0]   can_id;
		logic [8*DATA_LEN-1:0] payload;
	} frame_word_t;

	cfg_t         regs;
	logic [7:0]   win [FRAME_BYTES];
	int unsigned  fill;
	frame_word_t  expected_frames [$];

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
		fail_count++;
	endtask

	function automatic void deframe_byte(input logic [7:0] b);
		frame_word_t f;
		int k;
		if (fill >= FRAME_BYTES) begin
			for (k = 0; k < FRAME_BYTES - 1; k++) begin
				win[k] = win[k+1];
			end
			win[FRAME_BYTES-1] = b;
		end else begin
			win[fill] = b;
			fill++;
		end
		if (fill == FRAME_BYTES && win[0] == regs.header_byte &&
				win[FRAME_BYTES-1] == regs.tail_byte) begin
			if (win[CMD_POS] == regs.feedback_code) begin
				for (k = 0; k < ID_LEN; k++) begin
					f.can_id[8*k +: 8] = win[ID_POS+k];
				end
				for (k = 0; k < DATA_LEN; k++) begin
					f.payload[8*k +: 8] = win[DATA_POS+k];
				end
				expected_frames.push_back(f);
			end
			fill = 0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		frame_word_t want;
		if (!arst_n) begin
			regs.header_byte   = HEADER_RST;
			regs.tail_byte     = TAIL_RST;
			regs.feedback_code = FEEDBACK_RST;
			fill = 0;
			expected_frames.delete();
			fail_count = 0;
			pend_count = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.wr_index)
					REG_HEADER:   regs.header_byte   = cfg.wr_data;
					REG_TAIL:     regs.tail_byte     = cfg.wr_data;
					REG_FEEDBACK: regs.feedback_code = cfg.wr_data;
					default: ;
				endcase
			end
			if (rx.valid && rx.ready) begin
				deframe_byte(rx.rx_byte);
			end
			if (frame_out.valid && frame_out.ready) begin
				if (expected_frames.size() == 0) begin
					report_mismatch("frame with none pending", 64'd0,
						64'(frame_out.can_id));
				end else begin
					want = expected_frames.pop_front();
					if (frame_out.can_id !== want.can_id) begin
						report_mismatch("can_id", 64'(want.can_id), 64'(frame_out.can_id));
					end
					if (frame_out.payload !== want.payload) begin
						report_mismatch("payload", want.payload, frame_out.payload);
					end
				end
			end
			pend_count = expected_frames.size();
		end
	end

endmodule

[tb/sv/fixed_frame_serial_deframer_tb.sv]
`timescale 1ns / 100ps
// fixed_frame_serial_deframer_tb: drives received words and register writes into the
// deframer with random idling on both sides; the checker beside it judges the frames
// depends on ffsd_pkg, ffsd_if, ffsd_frame_checker and the deframer rtl
module fixed_frame_serial_deframer_tb;
	import ffsd_pkg::*;

	localparam int FRAME_BYTES = FRAME_BYTES_DEF;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet;
	bit   long_hold;
	bit   hold_taken;
	int   fail_count;
	int   pend_count;
	int   n_sent;

	logic [7:0] cur_hdr;
	logic [7:0] cur_tail;
	logic [7:0] cur_fb;

	ffsd_rx_if    rx_ch ();
	ffsd_frame_if frame_ch ();
	ffsd_cfg_if   cfg_ch ();

	fixed_frame_serial_deframer #(.FRAME_BYTES(FRAME_BYTES)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.frame_out (frame_ch),
		.cfg       (cfg_ch)
	);

	ffsd_frame_checker #(.FRAME_BYTES(FRAME_BYTES)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.frame_out  (frame_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pend_count (pend_count)
	);

	always #5 clk = ~clk;

	initial begin
		#(5_000_000);
		$display("status: fail");
		$finish;
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		frame_ch.ready = 1'b0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold && !hold_taken) begin
				hold_taken = 1'b1;
				frame_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
			end else if (quiet || $urandom_range(0, 3) != 0) begin
				frame_ch.ready <= 1'b1;
			end else begin
				frame_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			@(negedge clk);
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
		end
		@(negedge clk);
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
		n_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (pend_count != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_ch.valid    <= 1'b1;
		cfg_ch.wr_index <= idx;
		cfg_ch.wr_data  <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] hdr, input logic [7:0] tail,
			input logic [7:0] fb);
		write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
		write_reg(REG_TAIL, tail);
		write_reg(REG_FEEDBACK, fb);
		write_reg(REG_HEADER, hdr);
		cur_hdr  = hdr;
		cur_tail = tail;
		cur_fb   = fb;
	endtask

	// flaw: 0 clean, 1 bad header, 2 bad tail, 3 cut short
	task automatic send_frame(input bit emit, input int flaw);
		logic [7:0] fr [FRAME_BYTES];
		logic [7:0] flip;
		int len;
		int style;
		int k;
		style = $urandom_range(0, 9);
		for (k = 0; k < FRAME_BYTES; k++) begin
			fr[k] = (style == 0) ? 8'h00 : (style == 1) ? 8'hFF : 8'($urandom_range(0, 255));
		end
		fr[0] = cur_hdr;
		fr[CMD_POS] = 8'($urandom_range(0, 255));
		if (emit) fr[CMD_POS] = cur_fb;
		else if (fr[CMD_POS] == cur_fb) fr[CMD_POS] = ~cur_fb;
		fr[FRAME_BYTES-1] = cur_tail;
		flip = 8'($urandom_range(1, 255));
		len = FRAME_BYTES;
		case (flaw)
			1: fr[0] = fr[0] ^ flip;
			2: fr[FRAME_BYTES-1] = fr[FRAME_BYTES-1] ^ flip;
			3: len = $urandom_range(1, FRAME_BYTES - 1);
			default: ;
		endcase
		for (k = 0; k < len; k++) begin
			send_byte(fr[k]);
		end
	endtask

	task automatic run_units(input int target);
		int start;
		int r;
		start = n_sent;
		while (n_sent - start < target) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				send_frame(1'b1, 0);
			end else if (r < 70) begin
				send_frame(1'b0, 0);
			end else if (r < 82) begin
				send_frame(1'($urandom_range(0, 1)), int'($urandom_range(1, 3)));
			end else begin
				repeat ($urandom_range(1, 20)) begin
					send_byte(($urandom_range(0, 3) == 0) ? cur_hdr : 8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	initial begin
		int p;
		int n;
		arst_n          = 1'b0;
		quiet           = 1'b0;
		long_hold       = 1'b0;
		n_sent          = 0;
		rx_ch.valid     = 1'b0;
		rx_ch.rx_byte   = 8'h00;
		cfg_ch.valid    = 1'b0;
		cfg_ch.wr_index = REG_HEADER;
		cfg_ch.wr_data  = 8'h00;
		cur_hdr         = HEADER_RST;
		cur_tail        = TAIL_RST;
		cur_fb          = FEEDBACK_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// noise ahead of a frame, so the window slides onto it
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(HEADER_RST);
		send_byte(HEADER_RST);
		send_byte(FEEDBACK_RST);
		send_byte(8'h00);
		repeat (4) send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'hFE);
		send_byte(TAIL_RST);
		run_units(150);

		for (p = 0; p < 7; p++) begin
			wait_idle();
			case (p)
				0: set_config(8'h00, 8'hFF, 8'h00);
				1: set_config(8'hFF, 8'h00, 8'hFF);
				2: set_config(8'h5A, 8'h5A, 8'h5A);
				4: set_config(HEADER_RST, TAIL_RST, FEEDBACK_RST);
				default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			endcase
			if (p == 6) quiet = 1'b1;
			if (p == 3) begin
				long_hold = 1'b1;
				for (n = 0; n < 5; n++) send_frame(1'b1, 0);
			end
			if (p == 1) begin
				run_units(125);
				@(negedge clk);
				rx_ch.valid <= 1'b0;
				while (pend_count != 0) @(negedge clk);
				run_units(125);
			end else begin
				run_units(250);
			end
		end

		@(negedge clk);
		rx_ch.valid <= 1'b0;
		n = 0;
		while (pend_count != 0 && n < 10000) begin
			@(negedge clk);
			n++;
		end
		repeat (10) @(negedge clk);
		if (fail_count + pend_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
